/* design/whb_pkg.sv */
// Shared constants and character helpers for the word hash bucket counter.
package whb_pkg;

  localparam int DEF_BUCKETS = 1001;
  localparam int CHAR_W      = 8;
  localparam int HASH_W      = 32;
  localparam int HASH_SHIFT  = 4;
  localparam int BUCKET_W    = 10;
  localparam int COUNT_W     = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

  function automatic logic is_separator(input logic [CHAR_W-1:0] c);
    return c inside {8'h00, 8'h20, 8'h3f, 8'h21, 8'h27, 8'h22, 8'h3b, 8'h2c, 8'h2e,
                     8'h3a, 8'h2b, 8'h2d, 8'h2a, 8'h26, 8'h25, 8'h28, 8'h29, 8'h7b,
                     8'h7d, 8'h5b, 8'h5d, 8'h3c, 8'h3e, 8'h5c, 8'h09, 8'h0a};
  endfunction

  function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
    if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      return c - CASE_DIFF;
    end
    return c;
  endfunction

endpackage

/* design/whb_text_if.sv */
// Text byte channel: one request carries a byte and the end-of-text flag.
interface whb_text_if
  import whb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

/* design/whb_result_if.sv */
// Result channel: one request carries a bucket index and its new count.
interface whb_result_if
  import whb_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output bucket, output count, input ready);
  modport sink   (input valid, input bucket, input count, output ready);
endinterface

/* design/whb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module whb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* design/word_hash_bucket_counter.sv */
// Word hash bucket counter: splits text into words and counts them per hash bucket.
//
// The text channel takes one byte per request. Separator bytes and the
// end-of-text flag close the pending word; letters are folded to upper case
// and shifted into a 32-bit hash. A closed word produces one request on the
// result channel with its bucket (hash modulo BUCKETS) and the bucket's new,
// saturating count. Separators with no pending word produce nothing.
// Throughput is one byte per cycle when the receiver does not stall and no
// clear pass runs. After the closing byte is accepted, its hash is registered;
// the next stage sums per-byte residues from constant tables, the next reduces
// the sum and reads the count memory, the last increments and writes back, and
// the result then sits in the output register. Back-to-back words in the same
// bucket are handled by forwarding the last written count.
// After reset the count memory is cleared one entry per cycle; the text
// channel holds ready low during that pass.
// When the receiver stalls, the whole pipeline holds and the text channel
// drops ready until the output register empties.
module word_hash_bucket_counter
  import whb_pkg::*;
#(
  parameter int BUCKETS = DEF_BUCKETS
) (
  input  logic              clk,
  input  logic              rst,
  whb_text_if.sink          text,
  whb_result_if.source      result
);
  localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW = IW + 2;
  localparam int BYTES = HASH_W / CHAR_W;
  localparam int SYMS = 1 << CHAR_W;
  localparam logic [SW-1:0] B1 = SW'(BUCKETS);
  localparam logic [SW-1:0] B2 = SW'(2 * BUCKETS);
  localparam logic [IW-1:0] LAST_ADDR = IW'(BUCKETS - 1);

  typedef logic [BYTES-1:0][SYMS-1:0][IW-1:0] res_tab_t;

  function automatic res_tab_t build_tab();
    res_tab_t t;
    longint   w;
    w = 1;
    for (int i = 0; i < BYTES; i++) begin
      for (int b = 0; b < SYMS; b++) begin
        t[i][b] = IW'((longint'(b) * w) % BUCKETS);
      end
      w = (w * SYMS) % BUCKETS;
    end
    return t;
  endfunction

  localparam res_tab_t RES_TAB = build_tab();

  logic [HASH_W-1:0]  hash;
  logic               in_word;
  logic               clearing;
  logic [IW-1:0]      clr_addr;

  logic               s1_valid;
  logic [HASH_W-1:0]  s1_hash;
  logic               s2_valid;
  logic [SW-1:0]      s2_sum;
  logic               s3_valid;
  logic [IW-1:0]      s3_bucket;

  logic               wr_valid;
  logic [IW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;

  logic               out_valid;
  logic [BUCKET_W-1:0] out_bucket;
  logic [COUNT_W-1:0] out_count;

  logic               advance;
  logic               accept;
  logic               word_end;
  logic [CHAR_W-1:0]  folded;
  logic [SW-1:0]      sum_next;
  logic [SW-1:0]      red_half;
  logic [IW-1:0]      bucket_next;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] cur_count;
  logic [COUNT_W-1:0] count_next;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;

  assign advance     = !out_valid || result.ready;
  assign text.ready  = advance && !clearing;
  assign accept      = text.valid && text.ready;
  assign word_end    = text.end_of_text || is_separator(text.char_in);
  assign folded      = fold_upper(text.char_in);

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < BYTES; i++) begin
      sum_next = sum_next + SW'(RES_TAB[i][s1_hash[i*CHAR_W +: CHAR_W]]);
    end
  end

  assign red_half    = (s2_sum >= B2) ? s2_sum - B2 : s2_sum;
  assign bucket_next = IW'((red_half >= B1) ? red_half - B1 : red_half);

  assign cur_count  = (wr_valid && wr_addr == s3_bucket) ? wr_data : ram_rdata;
  assign count_next = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);

  assign ram_we    = clearing || (advance && s3_valid);
  assign ram_waddr = clearing ? clr_addr : s3_bucket;
  assign ram_wdata = clearing ? '0 : count_next;

  whb_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (BUCKETS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (advance),
    .raddr (bucket_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hash      <= '0;
      in_word   <= 1'b0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      wr_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + IW'(1);
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        if (word_end) begin
          hash    <= '0;
          in_word <= 1'b0;
        end else begin
          hash    <= (hash << HASH_SHIFT) | HASH_W'(folded);
          in_word <= 1'b1;
        end
      end
      if (advance) begin
        s1_valid  <= accept && word_end && in_word;
        s1_hash   <= hash;
        s2_valid  <= s1_valid;
        s2_sum    <= sum_next;
        s3_valid  <= s2_valid;
        s3_bucket <= bucket_next;
        out_valid <= s3_valid;
        out_bucket <= BUCKET_W'(s3_bucket);
        out_count <= count_next;
        if (s3_valid) begin
          wr_valid <= 1'b1;
          wr_addr  <= s3_bucket;
          wr_data  <= count_next;
        end
      end
    end
  end

  assign result.valid  = out_valid;
  assign result.bucket = out_bucket;
  assign result.count  = out_count;

endmodule

/* test/tb_top.sv */
// Testbench for word_hash_bucket_counter: directed and random text checked against a word predictor.
module tb_top;
  import whb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [COUNT_W-1:0]  count;
  } bucket_hit_t;

  localparam int N_BREAKS = 26;
  localparam logic [CHAR_W-1:0] BREAK_CHARS [N_BREAKS] = '{
    8'h00, 8'h20, 8'h3f, 8'h21, 8'h27, 8'h22, 8'h3b, 8'h2c, 8'h2e, 8'h3a, 8'h2b, 8'h2d, 8'h2a,
    8'h26, 8'h25, 8'h28, 8'h29, 8'h7b, 8'h7d, 8'h5b, 8'h5d, 8'h3c, 8'h3e, 8'h5c, 8'h09, 8'h0a
  };
  localparam int TOTAL_BYTES = 425;

  logic clk = 1'b0;
  logic rst = 1'b1;

  whb_text_if   text_ch ();
  whb_result_if result_ch ();

  word_hash_bucket_counter #(.BUCKETS(DEF_BUCKETS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  logic [HASH_W-1:0]  word_hash;
  logic               word_open;
  logic [COUNT_W-1:0] bucket_tally [DEF_BUCKETS];
  bucket_hit_t        pending_hits [$];

  int  error_count = 0;
  int  bytes_sent = 0;
  bit  text_gaps = 1'b1;
  bit  result_stalls = 1'b1;
  byte unsigned vocab [6][];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit is_word_break(input logic [CHAR_W-1:0] c);
    foreach (BREAK_CHARS[i]) begin
      if (BREAK_CHARS[i] == c) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void count_word_byte(input logic [CHAR_W-1:0] c, input logic eot);
    logic [CHAR_W-1:0] folded;
    int unsigned       idx;
    bucket_hit_t       hit;
    if (eot || is_word_break(c)) begin
      if (word_open) begin
        idx = word_hash % DEF_BUCKETS;
        if (bucket_tally[idx] != COUNT_MAX) begin
          bucket_tally[idx] = bucket_tally[idx] + 1;
        end
        hit.bucket = idx[BUCKET_W-1:0];
        hit.count  = bucket_tally[idx];
        pending_hits.push_back(hit);
      end
      word_hash = '0;
      word_open = 1'b0;
    end else begin
      folded = (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
      word_hash = (word_hash << 4) | HASH_W'(folded);
      word_open = 1'b1;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eot);
    int gap;
    gap = text_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      text_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_ch.valid       = 1'b1;
    text_ch.char_in     = c;
    text_ch.end_of_text = eot;
    do @(posedge clk); while (!text_ch.ready);
    count_word_byte(c, eot);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], 1'b0);
    end
  endtask

  function automatic logic [CHAR_W-1:0] pick_break();
    return BREAK_CHARS[$urandom_range(0, N_BREAKS - 1)];
  endfunction

  function automatic logic [CHAR_W-1:0] pick_word_byte();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 255)); while (is_word_break(c));
    return c;
  endfunction

  task automatic test_empty_words();
    send_byte(8'h20, 1'b0);
    send_byte("a", 1'b1);
    send_byte(8'h2c, 1'b0);
  endtask

  task automatic test_case_folding();
    send_text("az");
    send_byte(8'h00, 1'b0);
    send_text("AZ");
    send_byte(".", 1'b0);
  endtask

  task automatic test_high_bytes();
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_long_word();
    send_text("abcdefghij");
    send_byte(8'h0a, 1'b0);
  endtask

  task automatic test_random_text();
    int choice;
    int len;
    int w;
    logic [CHAR_W-1:0] c;
    for (int i = 0; i < 6; i++) begin
      vocab[i] = new[$urandom_range(1, 8)];
      for (int j = 0; j < vocab[i].size(); j++) begin
        vocab[i][j] = CHAR_W'($urandom_range(8'h41, 8'h5a));
      end
    end
    while (bytes_sent < TOTAL_BYTES) begin
      if ((bytes_sent / 50) % 4 == 3) begin
        text_gaps     = 1'b0;
        result_stalls = 1'b0;
      end else begin
        text_gaps     = ((bytes_sent / 50) % 4) != 1;
        result_stalls = ((bytes_sent / 50) % 4) != 2;
      end
      choice = $urandom_range(0, 99);
      if (choice < 45) begin
        w = $urandom_range(0, 5);
        for (int j = 0; j < vocab[w].size(); j++) begin
          c = vocab[w][j];
          if ($urandom_range(0, 1)) begin
            c = c + 8'h20;
          end
          send_byte(c, 1'b0);
        end
      end else if (choice < 80) begin
        len = $urandom_range(1, 12);
        repeat (len) send_byte(pick_word_byte(), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        end
        continue;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_byte(CHAR_W'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_byte(pick_break(), 1'b0);
      end
    end
    send_byte(CHAR_W'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(negedge clk);
    wait (!rst);
    forever begin
      stall = result_stalls ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    bucket_hit_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected result: bucket %0d, count %0d", result_ch.bucket, result_ch.count);
        error_count++;
      end else begin
        want = pending_hits.pop_front();
        if (result_ch.bucket !== want.bucket) begin
          $error("bucket mismatch: expected %0d, got %0d", want.bucket, result_ch.bucket);
          error_count++;
        end
        if (result_ch.count !== want.count) begin
          $error("count mismatch: expected %0d, got %0d", want.count, result_ch.count);
          error_count++;
        end
      end
    end
  end

  initial begin
    text_ch.valid       = 1'b0;
    text_ch.char_in     = '0;
    text_ch.end_of_text = 1'b0;
    word_hash = '0;
    word_open = 1'b0;
    foreach (bucket_tally[i]) begin
      bucket_tally[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_words();
    test_case_folding();
    test_high_bytes();
    test_long_word();
    test_random_text();
    text_ch.valid = 1'b0;

    wait (pending_hits.size() == 0);
    repeat (20) @(posedge clk);
    if (pending_hits.size() != 0) begin
      $error("%0d results never arrived", pending_hits.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
